// ===== design/iurf_pkg.sv =====
// ============================================================================
// iurf_pkg
// Shared types, constants and a helper function of the IPv6/UDP receive filter.
// ============================================================================
package iurf_pkg;

    localparam int POS_W   = 17;
    localparam int CSUM_W  = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Byte offsets inside the packet.
    localparam logic [POS_W-1:0] POS_VERSION   = 17'd0;
    localparam logic [POS_W-1:0] POS_PLEN_HI   = 17'd4;
    localparam logic [POS_W-1:0] POS_PLEN_LO   = 17'd5;
    localparam logic [POS_W-1:0] POS_NEXT_HDR  = 17'd6;
    localparam logic [POS_W-1:0] POS_CSUM_FROM = 17'd8;
    localparam logic [POS_W-1:0] POS_DEST_FROM = 17'd24;
    localparam logic [POS_W-1:0] POS_HDR_END   = 17'd40;
    localparam logic [POS_W-1:0] POS_SPORT_HI  = 17'd40;
    localparam logic [POS_W-1:0] POS_SPORT_LO  = 17'd41;
    localparam logic [POS_W-1:0] POS_DPORT_HI  = 17'd42;
    localparam logic [POS_W-1:0] POS_DPORT_LO  = 17'd43;
    localparam logic [POS_W-1:0] POS_ULEN_HI   = 17'd44;
    localparam logic [POS_W-1:0] POS_ULEN_LO   = 17'd45;

    localparam logic [3:0] IP_VERSION6   = 4'd6;
    localparam logic [7:0] NEXT_HDR_UDP  = 8'd17;
    localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
    localparam logic [CSUM_W-1:0] CSUM_GOOD = 17'h0FFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT    = 3'd4;

    // Filter mode flags and the full mode.
    localparam logic [1:0] MODE_DEST_FLAG = 2'b01;
    localparam logic [1:0] MODE_UDP_FLAG  = 2'b10;
    localparam logic [1:0] MODE_UDP_PORTS = 2'b11;

    // Verdict status codes.
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT_IP  = 4'd1;
    localparam logic [3:0] ST_VERSION   = 4'd2;
    localparam logic [3:0] ST_PLEN      = 4'd3;
    localparam logic [3:0] ST_NOT_UDP   = 4'd4;
    localparam logic [3:0] ST_SHORT_UDP = 4'd5;
    localparam logic [3:0] ST_UDP_LEN   = 4'd6;
    localparam logic [3:0] ST_CHECKSUM  = 4'd7;
    localparam logic [3:0] ST_DEST      = 4'd8;
    localparam logic [3:0] ST_DPORT     = 4'd9;
    localparam logic [3:0] ST_SPORT     = 4'd10;

    typedef struct packed {
        logic [1:0]   filter_mode;
        logic [127:0] dest_addr;
        logic [15:0]  src_port;
        logic [15:0]  dst_port;
    } iurf_cfg_t;

    // Everything the verdict needs about one finished packet.
    typedef struct packed {
        logic [POS_W-1:0]  total;
        logic [CSUM_W-1:0] csum;
        logic [15:0]       plen;
        logic [7:0]        next_hdr;
        logic              version_good;
        logic              dest_equal;
        logic [15:0]       udp_len;
        logic [15:0]       src_port;
        logic [15:0]       dst_port;
    } iurf_summary_t;

    // One ones'-complement accumulation step with end-around carry.
    function automatic logic [CSUM_W-1:0] csum_add(input logic [CSUM_W-1:0] acc,
                                                   input logic [15:0] word);
        logic [CSUM_W:0] s;
        s = {1'b0, acc} + {2'b00, word};
        return {1'b0, s[15:0]} + {{(CSUM_W-2){1'b0}}, s[CSUM_W:16]};
    endfunction

endpackage

// ===== design/iurf_front.sv =====
// ============================================================================
// iurf_front
// Byte parser: captures header fields, compares the destination address and
// accumulates the checksum; pushes one summary per packet into the queue.
// ============================================================================
module iurf_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,    // [7:0] data_byte
    input  logic                    s_tlast,
    input  iurf_pkg::iurf_cfg_t     cfg,
    input  logic                    q_full,
    output logic                    q_push,
    output iurf_pkg::iurf_summary_t q_push_data
);
    import iurf_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CSUM_W-1:0] csum_reg, csum_next;
    logic [7:0]        held_reg, held_next;
    logic [15:0]       plen_reg, plen_next;
    logic [7:0]        nh_reg, nh_next;
    logic              ver_reg, ver_next;
    logic              dest_eq_reg, dest_eq_next;
    logic [15:0]       ulen_reg, ulen_next;
    logic [15:0]       sport_reg, sport_next;
    logic [15:0]       dport_reg, dport_next;

    logic              accept_byte;
    logic [POS_W-1:0]  pos_inc;
    logic [7:0]        addr_byte;
    logic [15:0]       csum_word;
    logic              csum_en;

    assign s_tready    = !q_full;
    assign accept_byte = s_tvalid && s_tready;
    assign pos_inc     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    // Address byte k of the packet's destination field sits at bit 8*(15-k).
    assign addr_byte = cfg.dest_addr[{pos_reg[3], ~pos_reg[2:0], 3'b000} +: 8];

    always_comb begin
        held_next    = held_reg;
        plen_next    = plen_reg;
        nh_next      = nh_reg;
        ver_next     = ver_reg;
        dest_eq_next = dest_eq_reg;
        ulen_next    = ulen_reg;
        sport_next   = sport_reg;
        dport_next   = dport_reg;
        csum_word    = 16'h0000;
        csum_en      = 1'b0;

        priority if (pos_reg == POS_VERSION) begin
            ver_next = (s_tdata[7:4] == IP_VERSION6);
        end else if (pos_reg == POS_PLEN_HI) begin
            plen_next[15:8] = s_tdata;
        end else if (pos_reg == POS_PLEN_LO) begin
            plen_next[7:0] = s_tdata;
        end else if (pos_reg == POS_NEXT_HDR) begin
            nh_next = s_tdata;
        end else if (pos_reg == POS_SPORT_HI) begin
            sport_next[15:8] = s_tdata;
        end else if (pos_reg == POS_SPORT_LO) begin
            sport_next[7:0] = s_tdata;
        end else if (pos_reg == POS_DPORT_HI) begin
            dport_next[15:8] = s_tdata;
        end else if (pos_reg == POS_DPORT_LO) begin
            dport_next[7:0] = s_tdata;
        end else if (pos_reg == POS_ULEN_HI) begin
            ulen_next[15:8] = s_tdata;
        end else if (pos_reg == POS_ULEN_LO) begin
            ulen_next[7:0] = s_tdata;
        end else begin
        end

        if (pos_reg >= POS_DEST_FROM && pos_reg < POS_HDR_END &&
            addr_byte != s_tdata) begin
            dest_eq_next = 1'b0;
        end

        // An odd trailing byte is summed at once as a high byte with zero below.
        if (pos_reg >= POS_CSUM_FROM) begin
            if (!pos_reg[0]) begin
                held_next = s_tdata;
                if (s_tlast) begin
                    csum_word = {s_tdata, 8'h00};
                    csum_en   = 1'b1;
                end
            end else begin
                csum_word = {held_reg, s_tdata};
                csum_en   = 1'b1;
            end
        end

        csum_next = csum_en ? csum_add(csum_reg, csum_word) : csum_reg;
        pos_next  = pos_inc;
    end

    assign q_push                   = accept_byte && s_tlast;
    assign q_push_data.total        = pos_next;
    assign q_push_data.csum         = csum_next;
    assign q_push_data.plen         = plen_next;
    assign q_push_data.next_hdr     = nh_next;
    assign q_push_data.version_good = ver_next;
    assign q_push_data.dest_equal   = dest_eq_next;
    assign q_push_data.udp_len      = ulen_next;
    assign q_push_data.src_port     = sport_next;
    assign q_push_data.dst_port     = dport_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || q_push) begin
            pos_reg     <= '0;
            csum_reg    <= '0;
            held_reg    <= '0;
            plen_reg    <= '0;
            nh_reg      <= '0;
            ver_reg     <= 1'b0;
            dest_eq_reg <= 1'b1;
            ulen_reg    <= '0;
            sport_reg   <= '0;
            dport_reg   <= '0;
        end else if (accept_byte) begin
            pos_reg     <= pos_next;
            csum_reg    <= csum_next;
            held_reg    <= held_next;
            plen_reg    <= plen_next;
            nh_reg      <= nh_next;
            ver_reg     <= ver_next;
            dest_eq_reg <= dest_eq_next;
            ulen_reg    <= ulen_next;
            sport_reg   <= sport_next;
            dport_reg   <= dport_next;
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> (pos_reg == '0) && dest_eq_reg)
        else $error("front state not cleared after the last byte");

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == POS_MAX) && accept_byte && !s_tlast |=> (pos_reg == POS_MAX))
        else $error("byte position wrapped");

endmodule

// ===== design/iurf_queue.sv =====
// ============================================================================
// iurf_queue
// Small register queue of packet summaries between parser and verdict stage.
// ============================================================================
module iurf_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  iurf_pkg::iurf_summary_t push_data,
    output logic                    full,
    output logic                    head_valid,
    output iurf_pkg::iurf_summary_t head_data,
    input  logic                    pop
);
    import iurf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    iurf_summary_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("summary pushed into a full queue");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

// ===== design/iurf_verdict.sv =====
// ============================================================================
// iurf_verdict
// Finishes the checksum, runs the ordered checks and holds the verdict item
// in the output register until it is taken.
// ============================================================================
module iurf_verdict (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  iurf_pkg::iurf_cfg_t     cfg,
    input  logic                    head_valid,
    input  iurf_pkg::iurf_summary_t head_data,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata   // [0] accept, [4:1] status,
                                              // [20:5] payload_length, rest 0
);
    import iurf_pkg::*;

    logic              valid_reg;
    logic              accept_reg, accept_next;
    logic [3:0]        status_reg, status_next;
    logic [15:0]       plen_reg;
    logic [CSUM_W-1:0] csum_plen, csum_final;
    logic              udp_mode, dest_mode, port_mode;

    assign udp_mode  = (cfg.filter_mode & MODE_UDP_FLAG) != 2'b00;
    assign dest_mode = (cfg.filter_mode & MODE_DEST_FLAG) != 2'b00;
    assign port_mode = (cfg.filter_mode == MODE_UDP_PORTS);

    // Pseudo-header words: payload length and next header.
    assign csum_plen  = csum_add(head_data.csum, head_data.plen);
    assign csum_final = csum_add(csum_plen, {8'h00, head_data.next_hdr});

    always_comb begin
        priority if (head_data.total < POS_HDR_END) begin
            status_next = ST_SHORT_IP;
        end else if (!head_data.version_good) begin
            status_next = ST_VERSION;
        end else if ((head_data.total - POS_HDR_END) != {1'b0, head_data.plen}) begin
            status_next = ST_PLEN;
        end else if (udp_mode && head_data.next_hdr != NEXT_HDR_UDP) begin
            status_next = ST_NOT_UDP;
        end else if (udp_mode && head_data.plen < UDP_HDR_LEN) begin
            status_next = ST_SHORT_UDP;
        end else if (udp_mode && head_data.udp_len != head_data.plen) begin
            status_next = ST_UDP_LEN;
        end else if (udp_mode && csum_final != CSUM_GOOD) begin
            status_next = ST_CHECKSUM;
        end else if (dest_mode && !head_data.dest_equal) begin
            status_next = ST_DEST;
        end else if (port_mode && head_data.dst_port != cfg.dst_port) begin
            status_next = ST_DPORT;
        end else if (port_mode && head_data.src_port != cfg.src_port) begin
            status_next = ST_SPORT;
        end else begin
            status_next = ST_OK;
        end
        accept_next = (status_next == ST_OK);
    end

    assign pop      = head_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, plen_reg, status_reg, accept_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            accept_reg <= accept_next;
            status_reg <= status_next;
            plen_reg   <= head_data.plen;
        end
    end

    a_accept_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (accept_reg == (status_reg == ST_OK)))
        else $error("accept flag disagrees with status");

    a_status_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (status_reg <= ST_SPORT))
        else $error("status code out of range");

endmodule

// ===== design/ipv6_udp_receive_filter.sv =====
// ============================================================================
// ipv6_udp_receive_filter
// IPv6 packet filter with optional UDP, checksum, address and port checks.
// ============================================================================
// Packets enter one byte per item on the s_ channel, with s_tlast on the
// final byte, and the block accepts one byte every clock cycle while the
// queue is not full. For each packet one verdict item leaves on the m_
// channel: accept, status and the header's payload length. The byte parser
// runs one checksum add and one address byte compare per byte. At the last
// byte it writes a summary into a QUEUE_DEPTH-entry queue. The verdict
// stage moves the head summary into an output register that is empty or
// being taken. s_tready falls only while the queue is full, that is when
// the m_ side holds back more than QUEUE_DEPTH pending verdicts. The user
// must write configuration registers through cfg_we, cfg_index, cfg_wdata
// only while no packet is in flight; the block itself does not enforce it.
// ============================================================================
module ipv6_udp_receive_filter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // [0] accept, [4:1] status,
                                                         // [20:5] payload_length
    input  logic                              cfg_we,
    input  logic [iurf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [iurf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import iurf_pkg::*;

    iurf_cfg_t     cfg_reg;
    logic          q_full, q_push, q_head_valid, q_pop;
    iurf_summary_t q_push_data, q_head_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FILTER_MODE: cfg_reg.filter_mode      <= cfg_wdata[1:0];
                CFG_DEST_HIGH:   cfg_reg.dest_addr[127:64] <= cfg_wdata;
                CFG_DEST_LOW:    cfg_reg.dest_addr[63:0]   <= cfg_wdata;
                CFG_SRC_PORT:    cfg_reg.src_port         <= cfg_wdata[15:0];
                CFG_DST_PORT:    cfg_reg.dst_port         <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    iurf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    iurf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop)
    );

    iurf_verdict u_verdict (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== tb/ipv6_udp_verdict_check.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ipv6_udp_verdict_check
// Watches the byte and verdict channels of the IPv6/UDP receive filter.
// ============================================================================
// Every accepted byte goes through a cycle-free model of the parser. The
// model follows the register writes that it sees on the configuration port.
// At the last byte of a packet it queues the expected verdict. Each verdict
// that leaves the block is compared field by field with the oldest queued
// one. The error count and the number of outstanding verdicts go back to
// the testbench top.
// ============================================================================
module ipv6_udp_verdict_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [23:0]                     m_tdata,   // [0] accept, [4:1] status,
                                                       // [20:5] payload_length
    input  logic                            cfg_we,
    input  logic [iurf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iurf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              verdicts_pending
);
    import iurf_pkg::*;

    typedef struct packed {
        logic        accept;
        logic [3:0]  status;
        logic [15:0] plen;
    } verdict_t;

    verdict_t expected_verdicts[$];

    logic [1:0]  mode;
    logic [63:0] dest_hi;
    logic [63:0] dest_lo;
    logic [15:0] want_sport;
    logic [15:0] want_dport;

    logic [POS_W-1:0]  pos;
    logic [CSUM_W-1:0] csum;
    logic [7:0]        held;
    logic [15:0]       plen;
    logic [7:0]        nxt;
    logic              ver_ok;
    logic              dst_eq;
    logic [15:0]       ulen;
    logic [15:0]       sport;
    logic [15:0]       dport;

    int errs = 0;

    // Ones'-complement add: the carry out of bit 15 wraps around into bit 0.
    function automatic logic [CSUM_W-1:0] ones_sum_add(input logic [CSUM_W-1:0] acc,
                                                       input logic [15:0] w);
        logic [17:0] s;
        s = 18'(acc) + 18'(w);
        return 17'(s[15:0]) + 17'(s[17:16]);
    endfunction

    task automatic clear_packet();
        pos    = '0;
        csum   = '0;
        held   = '0;
        plen   = '0;
        nxt    = '0;
        ver_ok = 1'b0;
        dst_eq = 1'b1;
        ulen   = '0;
        sport  = '0;
        dport  = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        logic [4:0]       k;
        logic [63:0]      word;
        logic [POS_W-1:0] total;
        logic [3:0]       st;
        logic             udp_on;
        logic             dest_on;
        logic             ports_on;
        verdict_t         v;

        case (pos)
            POS_VERSION:  ver_ok = (b[7:4] == IP_VERSION6);
            POS_PLEN_HI:  plen[15:8] = b;
            POS_PLEN_LO:  plen[7:0] = b;
            POS_NEXT_HDR: nxt = b;
            POS_SPORT_HI: sport[15:8] = b;
            POS_SPORT_LO: sport[7:0] = b;
            POS_DPORT_HI: dport[15:8] = b;
            POS_DPORT_LO: dport[7:0] = b;
            POS_ULEN_HI:  ulen[15:8] = b;
            POS_ULEN_LO:  ulen[7:0] = b;
            default: ;
        endcase

        // The address arrives most significant byte first.
        if (pos >= POS_DEST_FROM && pos < POS_HDR_END) begin
            k = 5'(pos - POS_DEST_FROM);
            word = (k < 5'd8) ? dest_hi : dest_lo;
            if (word[(7 - int'(k[2:0])) * 8 +: 8] != b)
                dst_eq = 1'b0;
        end

        if (pos >= POS_CSUM_FROM) begin
            if (!pos[0])
                held = b;
            else
                csum = ones_sum_add(csum, {held, b});
        end

        if (pos != POS_MAX)
            pos = pos + 1'b1;

        if (last) begin
            total = pos;
            if (total[0] && total > POS_CSUM_FROM)
                csum = ones_sum_add(csum, {held, 8'h00});
            csum = ones_sum_add(csum, plen);
            csum = ones_sum_add(csum, {8'h00, nxt});

            udp_on   = |(mode & MODE_UDP_FLAG);
            dest_on  = |(mode & MODE_DEST_FLAG);
            ports_on = (mode == MODE_UDP_PORTS);

            if (total < POS_HDR_END)
                st = ST_SHORT_IP;
            else if (!ver_ok)
                st = ST_VERSION;
            else if (total - POS_HDR_END != {1'b0, plen})
                st = ST_PLEN;
            else if (udp_on && nxt != NEXT_HDR_UDP)
                st = ST_NOT_UDP;
            else if (udp_on && plen < UDP_HDR_LEN)
                st = ST_SHORT_UDP;
            else if (udp_on && ulen != plen)
                st = ST_UDP_LEN;
            else if (udp_on && csum != CSUM_GOOD)
                st = ST_CHECKSUM;
            else if (dest_on && !dst_eq)
                st = ST_DEST;
            else if (ports_on && dport != want_dport)
                st = ST_DPORT;
            else if (ports_on && sport != want_sport)
                st = ST_SPORT;
            else
                st = ST_OK;

            v.accept = (st == ST_OK);
            v.status = st;
            v.plen   = plen;
            expected_verdicts.push_back(v);
            clear_packet();
        end
    endtask

    task automatic compare_verdict(input logic [23:0] d);
        verdict_t v;

        if (expected_verdicts.size() == 0) begin
            $display("%0t: verdict %h arrived with none expected", $time, d);
            errs++;
        end else begin
            v = expected_verdicts.pop_front();
            if (d[0] !== v.accept) begin
                $display("%0t: accept expected %0b, got %0b", $time, v.accept, d[0]);
                errs++;
            end
            if (d[4:1] !== v.status) begin
                $display("%0t: status expected %0d, got %0d", $time, v.status, d[4:1]);
                errs++;
            end
            if (d[20:5] !== v.plen) begin
                $display("%0t: payload_length expected %h, got %h", $time, v.plen, d[20:5]);
                errs++;
            end
            if (d[23:21] !== 3'b000) begin
                $display("%0t: padding expected 0, got %b", $time, d[23:21]);
                errs++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode       = '0;
            dest_hi    = '0;
            dest_lo    = '0;
            want_sport = '0;
            want_dport = '0;
            clear_packet();
            expected_verdicts.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FILTER_MODE: mode = cfg_wdata[1:0];
                    CFG_DEST_HIGH:   dest_hi = cfg_wdata;
                    CFG_DEST_LOW:    dest_lo = cfg_wdata;
                    CFG_SRC_PORT:    want_sport = cfg_wdata[15:0];
                    CFG_DST_PORT:    want_dport = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                compare_verdict(m_tdata);
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tlast);
        end
        fail_count       <= errs;
        verdicts_pending <= expected_verdicts.size();
    end

endmodule

// ===== tb/tb_ipv6_udp_receive_filter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_ipv6_udp_receive_filter
// Packet-level stimulus for the IPv6/UDP receive filter.
// ============================================================================
// Builds IPv6/UDP packets with a correct checksum, then breaks one check at
// a time, truncates them or replaces them with noise. A directed run covers
// each verdict status, one-byte and truncated packets and odd UDP segments.
// Random phases then rotate through all filter modes with fresh register
// values. Both channels idle and stall at random. The verdict checker sits
// beside the block and reports errors back here.
// ============================================================================
module tb_ipv6_udp_receive_filter;
    import iurf_pkg::*;

    typedef enum int {
        F_GOOD,
        F_VERSION,
        F_PLEN,
        F_NOT_UDP,
        F_SHORT_UDP,
        F_ULEN,
        F_CSUM,
        F_DEST,
        F_DPORT,
        F_SPORT,
        F_LONG,
        F_NOISE
    } fault_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    verdicts_pending;

    logic [63:0] cur_dest_hi;
    logic [63:0] cur_dest_lo;
    logic [15:0] cur_sport;
    logic [15:0] cur_dport;
    logic [7:0]  pkt[$];
    bit          burst;
    int          bytes_sent;

    ipv6_udp_receive_filter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ipv6_udp_verdict_check u_verdict_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .fail_count       (fail_count),
        .verdicts_pending (verdicts_pending)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [63:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Builds one packet with a valid UDP checksum over the pseudo-header,
    // breaks it as asked, trims it to cut bytes if cut is nonzero, sends it.
    task automatic send_packet(input fault_t f, input int n, input int cut);
        logic [15:0] plen;
        logic [15:0] ulen;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [15:0] csum;
        logic [7:0]  nxt;
        logic [31:0] acc;
        int          i;

        plen = 16'(8 + n);
        if (f == F_SHORT_UDP)
            plen = 16'($urandom_range(0, 7));
        nxt = NEXT_HDR_UDP;
        if (f == F_NOT_UDP)
            nxt = nxt ^ 8'($urandom_range(1, 255));
        sp = cur_sport;
        if (f == F_SPORT)
            sp = sp ^ 16'($urandom_range(1, 65535));
        dp = cur_dport;
        if (f == F_DPORT)
            dp = dp ^ 16'($urandom_range(1, 65535));
        ulen = plen;
        if (f == F_ULEN)
            ulen = ulen ^ 16'($urandom_range(1, 65535));

        pkt.delete();
        pkt.push_back({IP_VERSION6, 4'($urandom)});
        repeat (3) pkt.push_back(8'($urandom));
        pkt.push_back(plen[15:8]);
        pkt.push_back(plen[7:0]);
        pkt.push_back(nxt);
        pkt.push_back(8'($urandom));
        repeat (16) pkt.push_back(8'($urandom));
        for (i = 0; i < 16; i++)
            pkt.push_back(i < 8 ? cur_dest_hi[(7 - i) * 8 +: 8] : cur_dest_lo[(15 - i) * 8 +: 8]);
        if (f == F_DEST) begin
            i = 24 + $urandom_range(0, 15);
            pkt[i] = pkt[i] ^ 8'($urandom_range(1, 255));
        end
        pkt.push_back(sp[15:8]);
        pkt.push_back(sp[7:0]);
        pkt.push_back(dp[15:8]);
        pkt.push_back(dp[7:0]);
        pkt.push_back(ulen[15:8]);
        pkt.push_back(ulen[7:0]);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        repeat (n) pkt.push_back(8'($urandom));
        if (f == F_SHORT_UDP)
            while (pkt.size() > 40 + int'(plen)) void'(pkt.pop_back());

        // Checksum field is zero while summing; an odd tail is padded low.
        acc = 32'(plen) + 32'(nxt);
        for (i = 8; i < pkt.size(); i += 2)
            acc = acc + 32'({pkt[i], (i + 1 < pkt.size()) ? pkt[i + 1] : 8'h00});
        acc = 32'(acc[15:0]) + 32'(acc[31:16]);
        acc = 32'(acc[15:0]) + 32'(acc[31:16]);
        csum = ~acc[15:0];
        if (pkt.size() >= 48) begin
            pkt[46] = csum[15:8];
            pkt[47] = csum[7:0];
        end

        case (f)
            F_VERSION: pkt[0] = pkt[0] ^ {4'($urandom_range(1, 15)), 4'h0};
            F_PLEN: begin
                if ($urandom_range(0, 1) == 0)
                    void'(pkt.pop_back());
                else
                    pkt.push_back(8'($urandom));
            end
            F_CSUM: begin
                if ($urandom_range(0, 1) == 0)
                    i = $urandom_range(8, 23);
                else
                    i = $urandom_range(46, pkt.size() - 1);
                pkt[i] = pkt[i] ^ 8'($urandom_range(1, 255));
            end
            F_LONG: while (pkt.size() < int'(POS_MAX) + 2) pkt.push_back(8'($urandom));
            F_NOISE: begin
                pkt.delete();
                repeat ($urandom_range(1, 60)) pkt.push_back(8'($urandom));
            end
            default: ;
        endcase
        if (cut > 0)
            while (pkt.size() > cut) void'(pkt.pop_back());

        burst = (pkt.size() > 1000) || ($urandom_range(0, 3) == 0);
        for (i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        bytes_sent += pkt.size();
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Unused bits of the mode and port writes carry random junk on purpose,
    // and a write to an unused index goes first.
    task automatic set_config(input logic [1:0] mode, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [15:0] sp,
                              input logic [15:0] dp);
        logic [63:0] mode_word;
        mode_word = {$urandom, $urandom};
        mode_word[1:0] = mode;
        cfg_write(CFG_DST_PORT + 3'($urandom_range(1, 3)), {$urandom, $urandom});
        cfg_write(CFG_FILTER_MODE, mode_word);
        cfg_write(CFG_DEST_HIGH, hi);
        cfg_write(CFG_DEST_LOW, lo);
        cfg_write(CFG_SRC_PORT, {$urandom, 16'($urandom), sp});
        cfg_write(CFG_DST_PORT, {$urandom, 16'($urandom), dp});
        cfg_we <= 1'b0;
        cur_dest_hi = hi;
        cur_dest_lo = lo;
        cur_sport   = sp;
        cur_dport   = dp;
    endtask

    // Waits until every verdict is out before the registers change.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int stall;
        m_tready = 1'b1;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 4) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(30, 300)) @(posedge aclk);
            end else begin
                stall = idle_len();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 6)) @(posedge aclk);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int     phase;
        int     r;
        int     n;
        int     cut;
        fault_t f;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        cur_dest_hi = '0;
        cur_dest_lo = '0;
        cur_sport   = '0;
        cur_dport   = '0;
        burst       = 1'b0;
        bytes_sent  = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: plain IPv6 checks only.
        send_packet(F_GOOD, 0, 1);
        send_packet(F_GOOD, 0, 5);
        send_packet(F_GOOD, 0, 39);
        send_packet(F_SHORT_UDP, 0, 0);
        send_packet(F_VERSION, 3, 0);
        send_packet(F_PLEN, 4, 0);
        send_packet(F_NOT_UDP, 2, 0);
        drain();

        set_config(MODE_UDP_PORTS, '1, '0, 16'hFFFF, 16'h0000);
        send_packet(F_GOOD, 0, 0);
        send_packet(F_GOOD, 1, 0);
        send_packet(F_GOOD, 16, 0);
        send_packet(F_NOT_UDP, 4, 0);
        send_packet(F_SHORT_UDP, 0, 0);
        send_packet(F_ULEN, 3, 0);
        send_packet(F_CSUM, 5, 0);
        send_packet(F_DEST, 2, 0);
        send_packet(F_DPORT, 6, 0);
        send_packet(F_SPORT, 7, 0);
        send_packet(F_VERSION, 0, 0);

        phase = 0;
        while (phase < 4 || bytes_sent < 1500) begin
            drain();
            set_config(2'(phase), pick_addr(), pick_addr(), pick_port(), pick_port());
            repeat ($urandom_range(2, 5)) begin
                r   = $urandom_range(0, 99);
                cut = 0;
                if (r < 50)
                    f = F_GOOD;
                else if (r < 55)
                    f = F_VERSION;
                else if (r < 60)
                    f = F_PLEN;
                else if (r < 64)
                    f = F_NOT_UDP;
                else if (r < 68)
                    f = F_SHORT_UDP;
                else if (r < 72)
                    f = F_ULEN;
                else if (r < 78)
                    f = F_CSUM;
                else if (r < 84)
                    f = F_DEST;
                else if (r < 88)
                    f = F_DPORT;
                else if (r < 92)
                    f = F_SPORT;
                else if (r < 97)
                    f = F_NOISE;
                else begin
                    f   = F_GOOD;
                    cut = $urandom_range(1, 47);
                end
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 100)
                                                : $urandom_range(0, 24);
                send_packet(f, n, cut);
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && verdicts_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
